>>> rtl/smsd_pkg.sv
// shared constants, types and neighbor link structs for the spike detector
package smsd_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int TWICE_W     = SAMPLE_BITS + 1;
    localparam int COUNT_W     = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(5);

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    // what a cell shows to its neighbors
    typedef struct packed {
        t_sample val;
        logic    lt_s;
        logic    lt_d;
    } t_nbr;

    // broadcast control for the whole row of cells
    typedef struct packed {
        logic    load;
        logic    del;
        logic    del_lt_s;
        t_sample sample;
        t_sample oldest;
    } t_cell_ctl;

endpackage

>>> rtl/sliding_median_spike_detector_core.sv
// sliding window median spike detector: row of sort cells, median tap, alert counter
// the result of an accepted request is registered and shows at the output from the next cycle
// throughput: one request per cycle unless stalled; every cell inserts and evicts in parallel
// the output register holds a result while stalled, and the input is stalled only then
// reset: window length 5, window empty, alert count zero; cell contents undefined until written
// a window length write restarts the window and keeps the alert count
module sliding_median_spike_detector_core import smsd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_checked,
    output logic                   o_alert,
    output logic [TWICE_W-1:0]     o_twice_median,
    output logic [COUNT_W-1:0]     o_alert_total,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LEN_W-1:0]       i_cfg_data
);

    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_fill;
    logic [LEN_W-1:0]   n_fill;
    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] n_cnt;
    logic               r_ovalid;
    logic               n_ovalid;
    logic               r_checked;
    logic               r_alert;
    logic [TWICE_W-1:0] r_twice;

    logic [LEN_W-1:0]   w_len;
    logic [IDX_W-1:0]   w_lo_idx;
    logic [IDX_W-1:0]   w_hi_idx;
    logic [IDX_W-1:0]   w_old_idx;
    logic               w_accept;
    logic               w_taken;
    logic               w_cfg_wr;
    logic               w_full;
    logic               w_alert;
    logic [TWICE_W-1:0] w_twice;
    t_sample            w_lo_val;
    t_sample            w_hi_val;
    t_sample            w_oldest;
    t_cell_ctl          w_ctl;
    t_nbr               w_nbr [WINDOW_MAX];
    t_sample            w_arr [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] w_cell_valid;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign o_stall     = r_ovalid && i_stall;
    assign w_accept    = i_valid && !o_stall;
    assign w_taken     = r_ovalid && !i_stall;

    // length zero acts as one, anything past the row acts as the full row
    always_comb begin
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_W'(WINDOW_MAX)) begin
            w_len = LEN_W'(WINDOW_MAX);
        end else begin
            w_len = r_len;
        end
    end

    assign w_full    = (r_fill >= w_len);
    assign w_lo_idx  = IDX_W'((w_len - LEN_W'(1)) >> 1);
    assign w_hi_idx  = IDX_W'(w_len >> 1);
    assign w_old_idx = IDX_W'(w_len - LEN_W'(1));

    // one-hot picks over the row
    always_comb begin
        w_lo_val = '0;
        w_hi_val = '0;
        w_oldest = '0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            if (w_lo_idx == IDX_W'(k)) w_lo_val = w_lo_val | w_nbr[k].val;
            if (w_hi_idx == IDX_W'(k)) w_hi_val = w_hi_val | w_nbr[k].val;
            if (w_old_idx == IDX_W'(k)) w_oldest = w_oldest | w_arr[k];
        end
    end

    assign w_twice = w_full ? (TWICE_W'(w_lo_val) + TWICE_W'(w_hi_val)) : '0;
    assign w_alert = w_full && (TWICE_W'(i_sample) >= w_twice);

    assign w_ctl = '{
        load:     w_accept,
        del:      w_full,
        del_lt_s: w_full && (w_oldest < i_sample),
        sample:   i_sample,
        oldest:   w_oldest
    };

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        t_nbr    w_prev;
        t_nbr    w_next;
        t_sample w_arr_in;

        assign w_cell_valid[g] = (LEN_W'(g) < r_fill);

        if (g == 0) begin : g_head
            assign w_prev   = '{val: '0, lt_s: 1'b1, lt_d: 1'b1};
            assign w_arr_in = i_sample;
        end else begin : g_body
            assign w_prev   = w_nbr[g-1];
            assign w_arr_in = w_arr[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_tail
            assign w_next = '{val: '0, lt_s: 1'b0, lt_d: 1'b0};
        end else begin : g_inner
            assign w_next = w_nbr[g+1];
        end

        smsd_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_cell_valid (w_cell_valid[g]),
            .i_prev       (w_prev),
            .i_next       (w_next),
            .i_arr_in     (w_arr_in),
            .o_nbr        (w_nbr[g]),
            .o_arr        (w_arr[g])
        );
    end

    always_comb begin
        n_fill = r_fill;
        if (w_cfg_wr) begin
            n_fill = '0;
        end else if (w_accept && !w_full) begin
            n_fill = r_fill + LEN_W'(1);
        end
    end

    assign n_cnt = (w_alert && (r_cnt != '1)) ? (r_cnt + COUNT_W'(1)) : r_cnt;

    always_comb begin
        n_ovalid = r_ovalid;
        if (w_accept) begin
            n_ovalid = 1'b1;
        end else if (w_taken) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_RESET;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_len <= i_cfg_data;
            end
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
            if (w_accept) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_checked <= w_full;
            r_alert   <= w_alert;
            r_twice   <= w_twice;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_checked      = r_checked;
    assign o_alert        = r_alert;
    assign o_twice_median = r_twice;
    assign o_alert_total  = r_cnt;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_len)
        else $error("fill level past window length");

    a_unchecked_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_checked) |-> (!r_alert && (r_twice == '0)))
        else $error("alert or median on an unchecked result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_alert && (r_cnt != '1)) |=> (r_cnt == $past(r_cnt) + COUNT_W'(1)))
        else $error("alert count did not advance");

    a_alert_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_alert) |=> (r_cnt == $past(r_cnt)))
        else $error("alert count moved without an alert");

endmodule

>>> rtl/smsd_cell.sv
// one cell of the sorted window row plus one stage of the arrival delay line
module smsd_cell import smsd_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_cell_valid,
    input  t_nbr      i_prev,
    input  t_nbr      i_next,
    input  t_sample   i_arr_in,
    output t_nbr      o_nbr,
    output t_sample   o_arr
);

    t_sample r_val;
    t_sample r_arr;
    t_sample n_val;
    logic    w_lt_s;
    logic    w_lt_d;
    logic    w_below;
    logic    w_at_prev;

    assign w_lt_s = i_cell_valid && (r_val < i_ctl.sample);
    assign w_lt_d = i_cell_valid && (r_val < i_ctl.oldest);

    assign o_nbr = '{val: r_val, lt_s: w_lt_s, lt_d: w_lt_d};
    assign o_arr = r_arr;

    // when the evicted value sits below the new sample, the insert point moves down one
    assign w_below   = i_ctl.del_lt_s ? i_next.lt_s : w_lt_s;
    assign w_at_prev = i_ctl.del_lt_s ? w_lt_s : i_prev.lt_s;

    always_comb begin
        if (w_below) begin
            n_val = (i_ctl.del && !w_lt_d) ? i_next.val : r_val;
        end else if (w_at_prev) begin
            n_val = i_ctl.sample;
        end else begin
            n_val = (i_ctl.del && !i_prev.lt_d) ? r_val : i_prev.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= n_val;
            r_arr <= i_arr_in;
        end
    end

endmodule

>>> dv/smsd_checker.sv
// checker for the spike detector: watches the request, result and length write ports, predicts each result and compares
module smsd_checker import smsd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_in_sample,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_checked,
    input  logic                   i_alert,
    input  logic [TWICE_W-1:0]     i_twice_median,
    input  logic [COUNT_W-1:0]     i_alert_total,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [LEN_W-1:0]       i_cfg_data,
    output int                     o_fail_cnt,
    output int                     o_pending
);

    typedef struct packed {
        logic               checked;
        logic               alert;
        logic [TWICE_W-1:0] twice_median;
        logic [COUNT_W-1:0] alert_total;
    } t_spike_result;

    t_spike_result      expected_q[$];
    int                 n_err = 0;

    logic [LEN_W-1:0]   win_len_reg;
    t_sample            sorted_win [WINDOW_MAX];
    t_sample            arrival [WINDOW_MAX];
    int                 ring_ptr;
    int                 fill_cnt;
    logic [COUNT_W-1:0] alert_cnt;

    function automatic int active_len();
        if (win_len_reg == 0) return 1;
        if (win_len_reg > WINDOW_MAX) return WINDOW_MAX;
        return int'(win_len_reg);
    endfunction

    // place s among the first n entries, keeping them ascending
    function automatic void sorted_place(int n, t_sample s);
        int pos;
        int i;
        pos = 0;
        while (pos < n && sorted_win[pos] < s) pos++;
        for (i = n; i > pos; i--) sorted_win[i] = sorted_win[i-1];
        sorted_win[pos] = s;
    endfunction

    function automatic t_spike_result predict_spike(t_sample s);
        t_spike_result      r;
        int                 len;
        int                 slot;
        int                 k;
        int                 i;
        logic               found;
        logic [TWICE_W-1:0] twice;
        len  = active_len();
        slot = ring_ptr % len;
        r    = '0;
        if (fill_cnt >= len) begin
            fill_cnt = len;
            // odd window: twice the middle value; even window: the sum of the two middle values
            if (len % 2 == 1) twice = TWICE_W'(sorted_win[(len-1)/2]) << 1;
            else twice = TWICE_W'(sorted_win[len/2]) + TWICE_W'(sorted_win[len/2-1]);
            r.checked      = 1'b1;
            r.twice_median = twice;
            if (TWICE_W'(s) >= twice) begin
                r.alert = 1'b1;
                if (alert_cnt != '1) alert_cnt++;
            end
            // evict the oldest; the largest goes if it were somehow missing
            k     = len - 1;
            found = 1'b0;
            for (i = 0; i < len; i++) begin
                if (!found && sorted_win[i] == arrival[slot]) begin
                    k     = i;
                    found = 1'b1;
                end
            end
            for (i = k; i < len - 1; i++) sorted_win[i] = sorted_win[i+1];
            sorted_place(len - 1, s);
        end else begin
            sorted_place(fill_cnt, s);
            fill_cnt++;
        end
        arrival[slot] = s;
        slot++;
        if (slot >= len) slot = 0;
        ring_ptr      = slot;
        r.alert_total = alert_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_spike_result got;
        t_spike_result want;
        if (!i_rst_n) begin
            win_len_reg = LEN_RESET;
            ring_ptr    = 0;
            fill_cnt    = 0;
            alert_cnt   = '0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_checked, i_alert, i_twice_median, i_alert_total};
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    n_err++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("checked", want.checked, got.checked);
                    check_field("alert", want.alert, got.alert);
                    check_field("twice_median", want.twice_median, got.twice_median);
                    check_field("alert_total", want.alert_total, got.alert_total);
                end
            end
            // a length write restarts the window, the alert count stays
            if (i_cfg_valid && i_cfg_ready) begin
                win_len_reg = i_cfg_data;
                fill_cnt    = 0;
                ring_ptr    = 0;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q = {expected_q, predict_spike(i_in_sample)};
            end
        end
        o_pending  <= expected_q.size();
        o_fail_cnt <= n_err;
    end

endmodule

>>> dv/tb_top.sv
// testbench top for the spike detector: clock, reset, requests, length writes and verdict
module tb_top;
    import smsd_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 130;
    localparam int N_PHASES    = 12;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_checked;
    logic               o_alert;
    logic [TWICE_W-1:0] o_twice_median;
    logic [COUNT_W-1:0] o_alert_total;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [LEN_W-1:0]   i_cfg_data;

    int err_cnt;
    int pending;
    int send_idle_pct;
    int recv_idle_pct = 0;
    int hold_tok = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cyc = 0;

    always #1 i_clk = ~i_clk;

    sliding_median_spike_detector_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_checked      (o_checked),
        .o_alert        (o_alert),
        .o_twice_median (o_twice_median),
        .o_alert_total  (o_alert_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    smsd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in_sample    (i_sample),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_checked      (o_checked),
        .i_alert        (o_alert),
        .i_twice_median (o_twice_median),
        .i_alert_total  (o_alert_total),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_cnt     (err_cnt),
        .o_pending      (pending)
    );

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_tok != hold_seen) begin
            hold_seen <= hold_tok;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    task automatic send_sample(input t_sample s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid and wait until every request has its result
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly values near a level, with spikes around twice it and some noise
    function automatic t_sample pick_sample(int level);
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 25) v = level;
        else if (pick < 45) v = level + $urandom_range(0, level / 2 + 1);
        else if (pick < 55) v = level - $urandom_range(0, level / 2);
        else if (pick < 65) v = 2 * level - $urandom_range(0, 1);
        else if (pick < 72) v = 2 * level + $urandom_range(0, 3);
        else if (pick < 80) v = $urandom_range(0, 1) ? 0 : 65535;
        else v = $urandom_range(0, 65535);
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return t_sample'(v);
    endfunction

    initial begin : stim
        t_sample len5_seq [9];
        t_sample len1_seq [5];
        t_sample len2_seq [6];
        int      len_list [N_PHASES];
        int      level;
        int      ph;
        int      n;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_sample      <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        send_idle_pct = 9;
        recv_idle_pct <= 87;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset length: fill, then exact threshold hits and misses
        len5_seq = '{16'd0, 16'd65535, 16'd65535, 16'd1, 16'd0, 16'd2, 16'd3, 16'd65535, 16'd4};
        foreach (len5_seq[i]) send_sample(len5_seq[i]);
        drain();
        // zero length acts as one: the median is the previous sample, so a zero flags whatever follows
        write_len(LEN_W'(0));
        len1_seq = '{16'd0, 16'd0, 16'd65535, 16'd32767, 16'd65535};
        foreach (len1_seq[i]) send_sample(len1_seq[i]);
        drain();
        // even window: largest possible twice_median
        write_len(LEN_W'(2));
        len2_seq = '{16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd1, 16'd2};
        foreach (len2_seq[i]) send_sample(len2_seq[i]);
        drain();

        len_list = '{32, 1, 63, 2, 16, 0, 31, 3, 33, 6, 4, $urandom_range(0, 63)};
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 4) begin
                send_idle_pct = 9;
                recv_idle_pct <= 87;
            end else if (ph < 8) begin
                send_idle_pct = 87;
                recv_idle_pct <= 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            write_len(LEN_W'(len_list[ph]));
            case ($urandom_range(0, 3))
                0: level = $urandom_range(0, 3);
                1: level = $urandom_range(0, 255);
                2: level = $urandom_range(16384, 32767);
                default: level = $urandom_range(0, 65535);
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while requests keep coming
                if (ph == 9 && n == 30) hold_tok <= hold_tok + 1;
                if ($urandom_range(0, 49) == 0) level = $urandom_range(0, 40000);
                send_sample(pick_sample(level));
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/smsd_pkg.sv
rtl/smsd_cell.sv
rtl/sliding_median_spike_detector_core.sv
dv/smsd_checker.sv
dv/tb_top.sv
